// File: rtl/assert_macros.svh
// Assertion macros shared by the quadratic root pipeline.
// Each macro assumes clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QRR_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define QRR_ASSERT(lbl, prop, msg)
`define QRR_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/qrr_pkg.sv
// Shared types and codes for the quadratic real root pipeline.
// No dependencies.
package qrr_pkg;

    typedef struct packed {
        logic a_zero;
        logic a_neg;
        logic d_neg;
    } qrr_flags_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_A_ZERO = 2'd1,
        STATUS_SAT    = 2'd2
    } qrr_status_t;

    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;

endpackage

// File: rtl/qrr_front.sv
// Discriminant front end: magnitudes, split partial products, sums, b*b - 4ac.
// Four register stages. Depends on qrr_pkg.
module qrr_front #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    input  logic signed [W-1:0]   c,
    output logic                  out_valid,
    output logic [2*W+1:0]        d,
    output logic signed [W-1:0]   a_out,
    output logic signed [W-1:0]   b_out,
    output qrr_pkg::qrr_flags_t   flags
);
    import qrr_pkg::*;

    localparam int L  = W / 2;
    localparam int H  = W - L;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 2;

    logic [3:0] valid_reg;

    // stage 1: magnitudes
    logic [W-1:0]        ma_next, mb_next, mc_next;
    logic [W-1:0]        ma1_reg, mb1_reg, mc1_reg;
    logic signed [W-1:0] a1_reg, b1_reg;
    logic                acneg1_reg, azero1_reg;

    // stage 2: partial products
    logic [2*L-1:0]      bll_next, all_next;
    logic [W-1:0]        blh_next, alh_next, ahl_next;
    logic [2*H-1:0]      bhh_next, ahh_next;
    logic [2*L-1:0]      bll2_reg, all2_reg;
    logic [W-1:0]        blh2_reg, alh2_reg, ahl2_reg;
    logic [2*H-1:0]      bhh2_reg, ahh2_reg;
    logic signed [W-1:0] a2_reg, b2_reg;
    logic                acneg2_reg, azero2_reg;

    // stage 3: full products
    logic [PW-1:0]       bb_next, ac_next;
    logic [PW-1:0]       bb3_reg;
    logic [DW-1:0]       ac43_reg;
    logic signed [W-1:0] a3_reg, b3_reg;
    logic                acneg3_reg, azero3_reg;

    // stage 4: discriminant
    logic [DW-1:0]       d_next;
    logic                dneg_next;
    logic [DW-1:0]       d4_reg;
    logic signed [W-1:0] a4_reg, b4_reg;
    qrr_flags_t          flags4_reg;

    assign ma_next = a[W-1] ? W'(~a + W'(1)) : W'(a);
    assign mb_next = b[W-1] ? W'(~b + W'(1)) : W'(b);
    assign mc_next = c[W-1] ? W'(~c + W'(1)) : W'(c);

    assign bll_next = mb1_reg[L-1:0] * mb1_reg[L-1:0];
    assign blh_next = mb1_reg[L-1:0] * mb1_reg[W-1:L];
    assign bhh_next = mb1_reg[W-1:L] * mb1_reg[W-1:L];
    assign all_next = ma1_reg[L-1:0] * mc1_reg[L-1:0];
    assign alh_next = ma1_reg[L-1:0] * mc1_reg[W-1:L];
    assign ahl_next = ma1_reg[W-1:L] * mc1_reg[L-1:0];
    assign ahh_next = ma1_reg[W-1:L] * mc1_reg[W-1:L];

    assign bb_next = (PW'(bhh2_reg) << (2 * L)) + (PW'(blh2_reg) << (L + 1))
                   + PW'(bll2_reg);
    assign ac_next = (PW'(ahh2_reg) << (2 * L)) + (PW'(alh2_reg) << L)
                   + (PW'(ahl2_reg) << L) + PW'(all2_reg);

    always_comb
    begin
        d_next    = '0;
        dneg_next = 1'b0;
        if (acneg3_reg)
        begin
            d_next = DW'(bb3_reg) + ac43_reg;
        end
        else if (DW'(bb3_reg) >= ac43_reg)
        begin
            d_next = DW'(bb3_reg) - ac43_reg;
        end
        else
        begin
            dneg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma1_reg    <= ma_next;
            mb1_reg    <= mb_next;
            mc1_reg    <= mc_next;
            a1_reg     <= a;
            b1_reg     <= b;
            acneg1_reg <= a[W-1] ^ c[W-1];
            azero1_reg <= (a == '0);

            bll2_reg   <= bll_next;
            blh2_reg   <= blh_next;
            bhh2_reg   <= bhh_next;
            all2_reg   <= all_next;
            alh2_reg   <= alh_next;
            ahl2_reg   <= ahl_next;
            ahh2_reg   <= ahh_next;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            acneg2_reg <= acneg1_reg;
            azero2_reg <= azero1_reg;

            bb3_reg    <= bb_next;
            ac43_reg   <= {ac_next, 2'b00};
            a3_reg     <= a2_reg;
            b3_reg     <= b2_reg;
            acneg3_reg <= acneg2_reg;
            azero3_reg <= azero2_reg;

            d4_reg            <= d_next;
            a4_reg            <= a3_reg;
            b4_reg            <= b3_reg;
            flags4_reg.a_zero <= azero3_reg;
            flags4_reg.a_neg  <= a3_reg[W-1];
            flags4_reg.d_neg  <= dneg_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign d         = d4_reg;
    assign a_out     = a4_reg;
    assign b_out     = b4_reg;
    assign flags     = flags4_reg;

endmodule

// File: rtl/qrr_sqrt.sv
// Pipelined integer square root, one result bit per stage, truncating.
// Carries a side bus alongside each item. Depends on qrr_pkg.
module qrr_sqrt #(
    parameter int W     = 32,
    parameter int SIDEW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2*W+1:0]     d,
    input  logic [SIDEW-1:0]   side,
    output logic               out_valid,
    output logic [W:0]         root,
    output logic [SIDEW-1:0]   side_out
);
    import qrr_pkg::*;

    localparam int DW = 2 * W + 2;
    localparam int N  = W + 1;

    logic             valid_reg [N];
    logic [W+2:0]     rem_reg   [N];
    logic [W:0]       root_reg  [N];
    logic [DW-1:0]    dsh_reg   [N];
    logic [SIDEW-1:0] side_reg  [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic             v_prev;
        logic [W+2:0]     rem_prev;
        logic [W:0]       root_prev;
        logic [DW-1:0]    dsh_prev;
        logic [SIDEW-1:0] side_prev;
        logic [W+4:0]     rem2, trial, diff;
        logic             fit;

        if (i == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign dsh_prev  = d;
            assign side_prev = side;
        end
        else
        begin : g_next
            assign v_prev    = valid_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign dsh_prev  = dsh_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // bring down the next two radicand bits and try the next root bit
        assign rem2  = {rem_prev, dsh_prev[DW-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign fit   = (rem2 >= trial);
        assign diff  = rem2 - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fit ? diff[W+2:0] : rem2[W+2:0];
                root_reg[i] <= {root_prev[W-1:0], fit};
                dsh_reg[i]  <= {dsh_prev[DW-3:0], 2'b00};
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// File: rtl/qrr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Numerator is scaled by the fraction bits before division. Depends on qrr_pkg.
module qrr_div #(
    parameter int W     = 32,
    parameter int F     = 16,
    parameter int SIDEW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [W+1:0]       num,
    input  logic [W:0]         den,
    input  logic [SIDEW-1:0]   side,
    output logic               out_valid,
    output logic [W+F+1:0]     quo,
    output logic [SIDEW-1:0]   side_out
);
    import qrr_pkg::*;

    localparam int NW = W + 2 + F;

    logic             valid_reg [NW];
    logic [W:0]       rem_reg   [NW];
    logic [NW-1:0]    quo_reg   [NW];
    logic [NW-1:0]    nsh_reg   [NW];
    logic [W:0]       den_reg   [NW];
    logic [SIDEW-1:0] side_reg  [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_step
        logic             v_prev;
        logic [W:0]       rem_prev;
        logic [NW-1:0]    quo_prev;
        logic [NW-1:0]    nsh_prev;
        logic [W:0]       den_prev;
        logic [SIDEW-1:0] side_prev;
        logic [W+1:0]     rem2, diff;
        logic             fit;

        if (i == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign quo_prev  = '0;
            assign nsh_prev  = NW'(num) << F;
            assign den_prev  = den;
            assign side_prev = side;
        end
        else
        begin : g_next
            assign v_prev    = valid_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign quo_prev  = quo_reg[i-1];
            assign nsh_prev  = nsh_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign rem2 = {rem_prev, nsh_prev[NW-1]};
        assign fit  = (rem2 >= {1'b0, den_prev});
        assign diff = rem2 - {1'b0, den_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fit ? diff[W:0] : rem2[W:0];
                quo_reg[i]  <= {quo_prev[NW-2:0], fit};
                nsh_reg[i]  <= {nsh_prev[NW-2:0], 1'b0};
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// File: rtl/quadratic_real_roots.sv
// Real roots of a*x^2 + b*x + c with fixed-point coefficients, fully pipelined.
// Stages, Q15.16 by default: four discriminant, one square root per root bit,
// a numerator stage, one divider per quotient bit, an output register. One
// transfer per cycle unless m_axis_tready is low with a result held, which stalls
// every stage at once. Reset clears the valid bits and the output valid only.
`include "assert_macros.svh"
module quadratic_real_roots #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // coef_a, coef_b, coef_c, zero pad
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // root_count, root_plus, root_minus, status, zero pad
    output logic [((2*COEF_WIDTH+4+7)/8)*8-1:0]        m_axis_tdata
);
    import qrr_pkg::*;

    localparam int W     = COEF_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int NW    = W + 2 + F;
    localparam int ODW   = ((2 * W + 4 + 7) / 8) * 8;
    localparam int FLW   = $bits(qrr_flags_t);
    localparam int SQSW  = 2 * W + FLW;
    localparam int DPSW  = FLW + 2;

    logic en;

    // front end
    logic                fr_valid;
    logic [2*W+1:0]      fr_d;
    logic signed [W-1:0] fr_a, fr_b;
    qrr_flags_t          fr_flags;

    // square root
    logic                sq_valid;
    logic [W:0]          sq_root;
    logic [SQSW-1:0]     sq_side;
    logic signed [W-1:0] sq_a, sq_b;
    qrr_flags_t          sq_flags;

    // numerator stage
    logic signed [W+2:0] b_ext, s_ext, num_p, num_m, negnum_p, negnum_m;
    logic [W-1:0]        ma;
    logic                n_valid_reg;
    logic [W+1:0]        mag_p_reg, mag_m_reg;
    logic [W:0]          den_reg;
    qrr_flags_t          n_flags_reg;
    logic                szero_reg, neg_p_reg, neg_m_reg;

    // dividers
    logic                dp_valid, dm_valid;
    logic [NW-1:0]       q_p, q_m;
    logic [DPSW-1:0]     dp_side;
    logic [0:0]          dm_side;
    qrr_flags_t          d_flags;
    logic                d_szero, d_neg_p, d_neg_m;

    // output stage
    logic [W-1:0]        maxpos;
    logic [NW-1:0]       lim_p, lim_m;
    logic                sat_p, sat_m;
    logic [W-1:0]        mag_p, mag_m, root_p, root_m;
    logic [1:0]          count_next, status_next;
    logic                m_valid_reg;
    logic [1:0]          count_reg, status_reg;
    logic [W-1:0]        plus_reg, minus_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    qrr_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .a         ($signed(s_axis_tdata[W-1:0])),
        .b         ($signed(s_axis_tdata[2*W-1:W])),
        .c         ($signed(s_axis_tdata[3*W-1:2*W])),
        .out_valid (fr_valid),
        .d         (fr_d),
        .a_out     (fr_a),
        .b_out     (fr_b),
        .flags     (fr_flags)
    );

    qrr_sqrt #(.W(W), .SIDEW(SQSW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .d         (fr_d),
        .side      ({fr_a, fr_b, fr_flags}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    assign sq_a     = $signed(sq_side[SQSW-1 -: W]);
    assign sq_b     = $signed(sq_side[FLW +: W]);
    assign sq_flags = qrr_flags_t'(sq_side[FLW-1:0]);

    // form -b + s and -b - s, split into magnitude and quotient sign
    assign b_ext    = (W+3)'(sq_b);
    assign s_ext    = $signed({2'b00, sq_root});
    assign num_p    = s_ext - b_ext;
    assign num_m    = (W+3)'(0) - s_ext - b_ext;
    assign negnum_p = (W+3)'(0) - num_p;
    assign negnum_m = (W+3)'(0) - num_m;
    assign ma       = sq_a[W-1] ? W'(~sq_a + W'(1)) : W'(sq_a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_p_reg   <= num_p[W+2] ? negnum_p[W+1:0] : num_p[W+1:0];
            mag_m_reg   <= num_m[W+2] ? negnum_m[W+1:0] : num_m[W+1:0];
            neg_p_reg   <= num_p[W+2] ^ sq_flags.a_neg;
            neg_m_reg   <= num_m[W+2] ^ sq_flags.a_neg;
            den_reg     <= {ma, 1'b0};
            n_flags_reg <= sq_flags;
            szero_reg   <= (sq_root == '0);
        end
    end

    qrr_div #(.W(W), .F(F), .SIDEW(DPSW)) u_div_plus (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid_reg),
        .num       (mag_p_reg),
        .den       (den_reg),
        .side      ({n_flags_reg, szero_reg, neg_p_reg}),
        .out_valid (dp_valid),
        .quo       (q_p),
        .side_out  (dp_side)
    );

    qrr_div #(.W(W), .F(F), .SIDEW(1)) u_div_minus (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid_reg),
        .num       (mag_m_reg),
        .den       (den_reg),
        .side      (neg_m_reg),
        .out_valid (dm_valid),
        .quo       (q_m),
        .side_out  (dm_side)
    );

    assign d_flags = qrr_flags_t'(dp_side[DPSW-1:2]);
    assign d_szero = dp_side[1];
    assign d_neg_p = dp_side[0];
    assign d_neg_m = dm_side[0];

    // saturate to the signed range; the negative limit is one larger
    assign maxpos = {1'b0, {(W-1){1'b1}}};
    assign lim_p  = NW'(maxpos) + NW'(d_neg_p);
    assign lim_m  = NW'(maxpos) + NW'(d_neg_m);
    assign sat_p  = (q_p > lim_p);
    assign sat_m  = (q_m > lim_m);
    assign mag_p  = sat_p ? lim_p[W-1:0] : q_p[W-1:0];
    assign mag_m  = sat_m ? lim_m[W-1:0] : q_m[W-1:0];
    assign root_p = d_neg_p ? W'(~mag_p + W'(1)) : mag_p;
    assign root_m = d_neg_m ? W'(~mag_m + W'(1)) : mag_m;

    always_comb
    begin
        if (d_flags.a_zero || d_flags.d_neg)
        begin
            count_next = COUNT_NONE;
        end
        else if (d_szero)
        begin
            count_next = COUNT_ONE;
        end
        else
        begin
            count_next = COUNT_TWO;
        end

        if (d_flags.a_zero)
        begin
            status_next = STATUS_A_ZERO;
        end
        else if (!d_flags.d_neg && (sat_p || sat_m))
        begin
            status_next = STATUS_SAT;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= dp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            plus_reg   <= (count_next == COUNT_NONE) ? '0 : root_p;
            minus_reg  <= (count_next == COUNT_NONE) ? '0 : root_m;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = ODW'({status_reg, minus_reg, plus_reg, count_reg});

    `QRR_ASSERT(a_lanes_aligned, dp_valid == dm_valid, "divider lanes out of step")
    `QRR_ASSERT(a_none_zero, m_valid_reg && count_reg == COUNT_NONE |-> plus_reg == '0 && minus_reg == '0, "roots given without a root count")
    `QRR_ASSERT(a_one_equal, m_valid_reg && count_reg == COUNT_ONE |-> plus_reg == minus_reg, "single root differs between lanes")
    `QRR_ASSERT(a_azero_none, m_valid_reg && status_reg == STATUS_A_ZERO |-> count_reg == COUNT_NONE, "zero leading coefficient with roots")
    `QRR_ASSERT_NEVER(a_bad_count, m_valid_reg && count_reg != COUNT_NONE && count_reg != COUNT_ONE && count_reg != COUNT_TWO, "root count out of range")

endmodule
